// ===== hdl/mlfqs_pkg.sv =====
// Shared types and constants of the MLFQS priority engine.
`default_nettype none
package mlfqs_pkg;

   // fixed field widths
   localparam int SLOT_IN_W = 6;
   localparam int NICE_W    = 6;
   localparam int FIX_W     = 32;
   localparam int READY_W   = 7;
   localparam int TPS_W     = 10;
   localparam int SLICE_W   = 8;
   localparam int LA100_W   = 13;
   localparam int CSR_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W      = 3;

   localparam int DEFAULT_PRI = 31;
   localparam int NICE_MAX    = 20;
   localparam int LA100_MAX   = 8191;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_NEWSLICE = 3'd1;
   localparam logic [OP_W-1:0] OP_CREATE   = 3'd2;
   localparam logic [OP_W-1:0] OP_SETNICE  = 3'd3;
   localparam logic [OP_W-1:0] OP_EXIT     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MLFQS_ON  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SLOT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TPS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE     = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_MOD,
      ST_MOD_WAIT,
      ST_LOAD_MUL,
      ST_LOAD_WR,
      ST_COEF,
      ST_COEF_WAIT,
      ST_DECAY_RD,
      ST_DECAY_MUL,
      ST_DECAY_WR,
      ST_PRI_RD,
      ST_PRI_WR,
      ST_CRT_RD,
      ST_CRT_WR,
      ST_NICE_RD,
      ST_NICE_WR,
      ST_RPT_RD,
      ST_RPT_MULRC,
      ST_RPT_MULLA,
      ST_RPT_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/mlfqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlfqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hdl/mlfqs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module mlfqs_div #(
   parameter int DW = 46,
   parameter int VW = 33
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] quotient,
   output logic      [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] r_ff;
   logic [VW-1:0] d_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   r_sh;
   logic          fits;

   // trial subtract of the shifted partial remainder
   assign r_sh = {r_ff, q_ff[DW-1]};
   assign fits = r_sh >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(DW);
         q_ff    <= dividend;
         r_ff    <= '0;
         d_ff    <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DW-2:0], fits};
         r_ff   <= fits ? VW'(r_sh - {1'b0, d_ff}) : r_sh[VW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff))
      else $error("divider done while busy");
`endif

endmodule
`default_nettype wire

// ===== hdl/mlfqs_priority_engine_unit.sv =====
// Top level of the MLFQS priority engine: slot table, sequencer and fixed-point datapath.
// Create and set nice read then write the table before the report; new slice and exit only report.
// With MLFQS on, a tick bumps the running slot's recent CPU, then divides the tick count by the rate;
// a second boundary adds a load average update, a division for the decay coefficient and a decay pass
// over live slots; a priority boundary adds a priority pass (single table read port).
// One item at a time; reset clears control state and written marks: unwritten entries read as reset.
`default_nettype none
module mlfqs_priority_engine_unit #(
   parameter int SLOTS         = 64,
   parameter int FRACTION_BITS = 14,
   parameter int TOP_PRIORITY  = 63,
   localparam int PRW = ($clog2(TOP_PRIORITY + 1) > 5) ? $clog2(TOP_PRIORITY + 1) : 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [5:0]         req_slot,
   input  wire logic [5:0]         req_parent_slot,
   input  wire logic signed [5:0]  req_nice_value,
   input  wire logic [6:0]         req_ready_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [PRW-1:0]          rsp_priority_out,
   output logic signed [31:0]      rsp_recent_cpu_x100,
   output logic [12:0]             rsp_load_avg_x100,
   output logic                    rsp_yield_now,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [9:0]         csr_data
);

   localparam int IW      = $clog2(SLOTS);
   localparam int FB      = FRACTION_BITS;
   localparam int NW      = mlfqs_pkg::NICE_W;
   localparam int MUL_B_W = FB + 2;
   localparam int PW      = 32 + MUL_B_W;
   localparam int PV_W    = 36;
   localparam int DIV_DW  = 32 + FB;
   localparam int DIV_VW  = 33;
   localparam int MW      = NW + 32 + PRW;

   localparam logic signed [MUL_B_W-1:0] C59  = MUL_B_W'((59 * (1 << FB)) / 60);
   localparam logic signed [MUL_B_W-1:0] K100 = MUL_B_W'(100);
   localparam logic [FB-1:0]             T2   = FB'((1 << FB) / 60);
   localparam logic signed [PW-1:0]      FM1  = PW'((64'sd1 <<< FB) - 64'sd1);
   localparam logic signed [PW-1:0]      HALF = PW'(64'sd1 <<< (FB - 1));
   localparam logic signed [PW-1:0]      ZP   = '0;
   localparam logic signed [PW:0]        FONE_S = (PW+1)'(64'sd1 <<< FB);
   localparam logic signed [PW:0]        MAXV = {{(PW-30){1'b0}}, {31{1'b1}}};
   localparam logic signed [PW:0]        MINV = {{(PW-30){1'b1}}, {31{1'b0}}};
   localparam logic signed [PV_W-1:0]    TOPF = PV_W'(64'(TOP_PRIORITY) <<< FB);
   localparam logic signed [PV_W-1:0]    FM1V = PV_W'((64'sd1 <<< FB) - 64'sd1);
   localparam logic signed [PV_W-1:0]    TOPV = PV_W'(TOP_PRIORITY);
   localparam logic [PRW-1:0]            DEFP = PRW'(mlfqs_pkg::DEFAULT_PRI);

   // ---------------- helper functions ----------------
   // slot number modulo table size, binary restoring reduction
   function automatic logic [IW-1:0] slot_mod(input logic [5:0] x);
      logic [13:0] r;
      logic [13:0] m;
      r = 14'(x);
      for (int k = 5; k >= 0; k--) begin
         m = 14'(SLOTS) << k;
         if (r >= m) r = r - m;
      end
      return r[IW-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
      if (v > MAXV) return 32'sh7fffffff;
      if (v < MINV) return 32'sh80000000;
      return v[31:0];
   endfunction

   // divide by one, truncating toward zero
   function automatic logic signed [PW-1:0] trunc_f(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v + (v[PW-1] ? FM1 : ZP);
      return t >>> FB;
   endfunction

   // times-100 value back to integer, half away from zero
   function automatic logic signed [PW-1:0] round_f(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      if (!v[PW-1]) begin
         t = (v + HALF) >>> FB;
      end else begin
         t = (HALF - v) >>> FB;
         t = -t;
      end
      return t;
   endfunction

   function automatic logic [PRW-1:0] prio_f(input logic signed [NW-1:0] nice,
                                             input logic signed [31:0] rc);
      logic signed [PV_W-1:0] r;
      logic signed [PV_W-1:0] q4;
      logic signed [PV_W-1:0] v;
      logic signed [PV_W-1:0] q;
      r = PV_W'(rc);
      if (rc[31]) r = r + PV_W'(3);
      q4 = r >>> 2;
      v = TOPF - q4 - (PV_W'(nice) <<< (FB + 1));
      if (v[PV_W-1]) v = v + FM1V;
      q = v >>> FB;
      if (q[PV_W-1]) return '0;
      if (q > TOPV) return PRW'(TOP_PRIORITY);
      return q[PRW-1:0];
   endfunction

   // ---------------- registers ----------------
   mlfqs_pkg::state_type state_ff, state_in;

   logic                    cfg_on_ff;
   logic [5:0]              cfg_idle_ff;
   logic [9:0]              cfg_tps_ff;
   logic [7:0]              cfg_slice_ff;

   logic [2:0]              op_ff;
   logic [IW-1:0]           s_ff;
   logic [IW-1:0]           p_ff;
   logic signed [NW-1:0]    nv_ff;
   logic [6:0]              ready_ff;
   logic [IW-1:0]           idx_ff;
   logic [FB-1:0]           coeff_ff;
   logic signed [PW-1:0]    mul_ff;
   logic signed [31:0]      rc100_ff;
   logic                    yield_ff;
   logic [31:0]             tick_ff;
   logic [7:0]              slice_ff;
   logic signed [31:0]      la_ff;
   logic [SLOTS-1:0]        live_ff;
   logic [SLOTS-1:0]        wr_ff;
   logic                    rdv_ff;

   logic                    rsp_valid_ff;
   logic [PRW-1:0]          rsp_pri_ff;
   logic signed [31:0]      rsp_rc_ff;
   logic [12:0]             rsp_la_ff;
   logic                    rsp_yield_ff;

   // ---------------- combinational helpers ----------------
   logic [IW-1:0]        idle_idx;
   logic [IW-1:0]        s_in;
   logic [IW-1:0]        p_in;
   logic signed [NW-1:0] nv_in;
   logic [7:0]           slice_in;
   logic [9:0]           tps_eff;
   logic                 s_idle;
   logic                 sweep_take;
   logic                 idx_last;
   logic                 prio_due;
   logic                 accept;
   logic                 out_go;

   assign idle_idx = slot_mod(cfg_idle_ff);
   assign s_in     = slot_mod(req_slot);
   assign p_in     = slot_mod(req_parent_slot);
   assign slice_in = (slice_ff != 8'hFF) ? slice_ff + 8'd1 : slice_ff;
   assign tps_eff  = (cfg_tps_ff == 10'd0) ? 10'd1 : cfg_tps_ff;
   assign s_idle   = (s_ff == idle_idx);
   assign sweep_take = live_ff[idx_ff] && (idx_ff != idle_idx);
   assign idx_last = (idx_ff == IW'(SLOTS - 1));
   assign prio_due = (tick_ff[1:0] == 2'd0);
   assign accept   = req_valid && !req_stall;
   assign out_go   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_nice_value > 6'sd20) begin
         nv_in = 6'sd20;
      end else if (req_nice_value < -6'sd20) begin
         nv_in = -6'sd20;
      end else begin
         nv_in = req_nice_value;
      end
   end

   // table read data, never-written entries read as reset values
   logic [MW-1:0]        ram_rdata;
   logic signed [NW-1:0] rd_nice;
   logic signed [31:0]   rd_rc;
   logic [PRW-1:0]       rd_pri;

   assign rd_nice = rdv_ff ? ram_rdata[MW-1 -: NW] : '0;
   assign rd_rc   = rdv_ff ? ram_rdata[PRW +: 32] : '0;
   assign rd_pri  = rdv_ff ? ram_rdata[PRW-1:0] : DEFP;

   // datapath values
   logic signed [31:0]   rc_inc;
   logic signed [31:0]   rc_dec;
   logic signed [31:0]   la_in;
   logic [7:0]           load_n;
   logic [FB+7:0]        term2;
   logic signed [PW-1:0] mul_t;
   logic signed [PW-1:0] rnd_t;
   logic [12:0]          la100;

   assign rc_inc = sat32((PW+1)'(rd_rc) + FONE_S);
   assign mul_t  = trunc_f(mul_ff);
   assign rc_dec = sat32((PW+1)'(mul_t) + ((PW+1)'(rd_nice) <<< FB));
   assign load_n = {1'b0, ready_ff} + (s_idle ? 8'd0 : 8'd1);
   assign term2  = T2 * load_n;
   assign la_in  = sat32((PW+1)'(mul_t) + (PW+1)'($signed({1'b0, term2})));
   assign rnd_t  = round_f(mul_ff);

   always_comb begin
      if (rnd_t[PW-1]) begin
         la100 = '0;
      end else if (rnd_t > PW'(mlfqs_pkg::LA100_MAX)) begin
         la100 = 13'(mlfqs_pkg::LA100_MAX);
      end else begin
         la100 = rnd_t[12:0];
      end
   end

   // shared multiplier operand select
   logic signed [31:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   always_comb begin
      mul_a = rd_rc;
      mul_b = K100;
      case (state_ff)
         mlfqs_pkg::ST_DECAY_MUL: begin
            mul_a = rd_rc;
            mul_b = MUL_B_W'($signed({1'b0, coeff_ff}));
         end
         mlfqs_pkg::ST_LOAD_MUL: begin
            mul_a = la_ff;
            mul_b = C59;
         end
         mlfqs_pkg::ST_RPT_MULLA: begin
            mul_a = la_ff;
            mul_b = K100;
         end
         default: begin
            mul_a = rd_rc;
            mul_b = K100;
         end
      endcase
   end

   // divider
   logic                div_start;
   logic [DIV_DW-1:0]   div_dividend;
   logic [DIV_VW-1:0]   div_divisor;
   logic                div_done;
   logic [DIV_DW-1:0]   div_quo;
   logic [DIV_VW-1:0]   div_rem;
   logic [DIV_VW-1:0]   twice;

   assign twice = {la_ff, 1'b0};

   mlfqs_div #(
      .DW(DIV_DW),
      .VW(DIV_VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // table memory
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;

   mlfqs_ram #(
      .WIDTH(MW),
      .DEPTH(SLOTS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      mem_we       = 1'b0;
      mem_waddr    = s_ff;
      mem_wdata    = {rd_nice, rd_rc, rd_pri};
      mem_re       = 1'b0;
      mem_raddr    = s_ff;
      div_start    = 1'b0;
      div_dividend = DIV_DW'(tick_ff);
      div_divisor  = DIV_VW'(tps_eff);
      case (state_ff)
         mlfqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  mlfqs_pkg::OP_TICK: begin
                     if (!cfg_on_ff) begin
                        state_in = mlfqs_pkg::ST_RPT_RD;
                     end else if (s_in != idle_idx) begin
                        state_in = mlfqs_pkg::ST_TICK_RD;
                     end else begin
                        state_in = mlfqs_pkg::ST_MOD;
                     end
                  end
                  mlfqs_pkg::OP_CREATE:  state_in = mlfqs_pkg::ST_CRT_RD;
                  mlfqs_pkg::OP_SETNICE: state_in = mlfqs_pkg::ST_NICE_RD;
                  default:               state_in = mlfqs_pkg::ST_RPT_RD;
               endcase
            end
         end
         mlfqs_pkg::ST_TICK_RD: begin
            mem_re   = 1'b1;
            state_in = mlfqs_pkg::ST_TICK_WR;
         end
         mlfqs_pkg::ST_TICK_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {rd_nice, rc_inc, rd_pri};
            state_in  = mlfqs_pkg::ST_MOD;
         end
         mlfqs_pkg::ST_MOD: begin
            div_start = 1'b1;
            state_in  = mlfqs_pkg::ST_MOD_WAIT;
         end
         mlfqs_pkg::ST_MOD_WAIT: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  state_in = mlfqs_pkg::ST_LOAD_MUL;
               end else if (prio_due) begin
                  state_in = mlfqs_pkg::ST_PRI_RD;
               end else begin
                  state_in = mlfqs_pkg::ST_RPT_RD;
               end
            end
         end
         mlfqs_pkg::ST_LOAD_MUL: state_in = mlfqs_pkg::ST_LOAD_WR;
         mlfqs_pkg::ST_LOAD_WR:  state_in = mlfqs_pkg::ST_COEF;
         mlfqs_pkg::ST_COEF: begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(twice) << FB;
            div_divisor  = twice + DIV_VW'(64'd1 << FB);
            state_in     = mlfqs_pkg::ST_COEF_WAIT;
         end
         mlfqs_pkg::ST_COEF_WAIT: begin
            if (div_done) state_in = mlfqs_pkg::ST_DECAY_RD;
         end
         mlfqs_pkg::ST_DECAY_RD: begin
            mem_raddr = idx_ff;
            if (sweep_take) begin
               mem_re   = 1'b1;
               state_in = mlfqs_pkg::ST_DECAY_MUL;
            end else if (idx_last) begin
               state_in = prio_due ? mlfqs_pkg::ST_PRI_RD : mlfqs_pkg::ST_RPT_RD;
            end
         end
         mlfqs_pkg::ST_DECAY_MUL: state_in = mlfqs_pkg::ST_DECAY_WR;
         mlfqs_pkg::ST_DECAY_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = {rd_nice, rc_dec, rd_pri};
            if (idx_last) begin
               state_in = prio_due ? mlfqs_pkg::ST_PRI_RD : mlfqs_pkg::ST_RPT_RD;
            end else begin
               state_in = mlfqs_pkg::ST_DECAY_RD;
            end
         end
         mlfqs_pkg::ST_PRI_RD: begin
            mem_raddr = idx_ff;
            if (sweep_take) begin
               mem_re   = 1'b1;
               state_in = mlfqs_pkg::ST_PRI_WR;
            end else if (idx_last) begin
               state_in = mlfqs_pkg::ST_RPT_RD;
            end
         end
         mlfqs_pkg::ST_PRI_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = {rd_nice, rd_rc, prio_f(rd_nice, rd_rc)};
            state_in  = idx_last ? mlfqs_pkg::ST_RPT_RD : mlfqs_pkg::ST_PRI_RD;
         end
         mlfqs_pkg::ST_CRT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = p_ff;
            state_in  = mlfqs_pkg::ST_CRT_WR;
         end
         mlfqs_pkg::ST_CRT_WR: begin
            mem_we = 1'b1;
            if (!cfg_on_ff) begin
               mem_wdata = {NW'(0), 32'sd0, DEFP};
            end else if (s_idle) begin
               mem_wdata = {rd_nice, rd_rc, DEFP};
            end else begin
               mem_wdata = {rd_nice, rd_rc, prio_f(rd_nice, rd_rc)};
            end
            state_in = mlfqs_pkg::ST_RPT_RD;
         end
         mlfqs_pkg::ST_NICE_RD: begin
            mem_re   = 1'b1;
            state_in = mlfqs_pkg::ST_NICE_WR;
         end
         mlfqs_pkg::ST_NICE_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {nv_ff, rd_rc, s_idle ? rd_pri : prio_f(nv_ff, rd_rc)};
            state_in  = mlfqs_pkg::ST_RPT_RD;
         end
         mlfqs_pkg::ST_RPT_RD: begin
            mem_re   = 1'b1;
            state_in = mlfqs_pkg::ST_RPT_MULRC;
         end
         mlfqs_pkg::ST_RPT_MULRC: state_in = mlfqs_pkg::ST_RPT_MULLA;
         mlfqs_pkg::ST_RPT_MULLA: state_in = mlfqs_pkg::ST_RPT_OUT;
         mlfqs_pkg::ST_RPT_OUT: begin
            if (out_go) state_in = mlfqs_pkg::ST_IDLE;
         end
         default: state_in = mlfqs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlfqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath and state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_on_ff    <= 1'b1;
         cfg_idle_ff  <= '0;
         cfg_tps_ff   <= 10'd100;
         cfg_slice_ff <= 8'd4;
         tick_ff      <= '0;
         slice_ff     <= '0;
         la_ff        <= '0;
         live_ff      <= '0;
         wr_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_write) begin
            case (csr_index)
               mlfqs_pkg::CSR_MLFQS_ON:  cfg_on_ff    <= csr_data[0];
               mlfqs_pkg::CSR_IDLE_SLOT: cfg_idle_ff  <= csr_data[5:0];
               mlfqs_pkg::CSR_TPS:       cfg_tps_ff   <= csr_data;
               mlfqs_pkg::CSR_SLICE:     cfg_slice_ff <= csr_data[7:0];
               default: ;
            endcase
         end

         // beat accepted on the request side
         if (accept) begin
            op_ff    <= req_opcode;
            s_ff     <= s_in;
            p_ff     <= p_in;
            nv_ff    <= nv_in;
            ready_ff <= req_ready_count;
            yield_ff <= 1'b0;
            idx_ff   <= '0;
            case (req_opcode)
               mlfqs_pkg::OP_TICK: begin
                  tick_ff  <= tick_ff + 32'd1;
                  slice_ff <= slice_in;
                  yield_ff <= (slice_in >= cfg_slice_ff);
               end
               mlfqs_pkg::OP_NEWSLICE: slice_ff <= '0;
               mlfqs_pkg::OP_EXIT:     live_ff[s_in] <= 1'b0;
               default: ;
            endcase
         end

         if (mem_we) wr_ff[mem_waddr] <= 1'b1;
         if (state_ff == mlfqs_pkg::ST_CRT_WR) live_ff[s_ff] <= 1'b1;
         if (state_ff == mlfqs_pkg::ST_LOAD_WR) la_ff <= la_in;

         // sweep index wraps to zero at the end of each pass
         if ((state_ff == mlfqs_pkg::ST_DECAY_RD && !sweep_take) ||
             (state_ff == mlfqs_pkg::ST_PRI_RD && !sweep_take) ||
             state_ff == mlfqs_pkg::ST_DECAY_WR || state_ff == mlfqs_pkg::ST_PRI_WR) begin
            idx_ff <= idx_last ? '0 : idx_ff + IW'(1);
         end

         // result register
         if (state_ff == mlfqs_pkg::ST_RPT_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (mem_re) rdv_ff <= wr_ff[mem_raddr];
      if (state_ff == mlfqs_pkg::ST_COEF_WAIT && div_done) coeff_ff <= div_quo[FB-1:0];
      if (state_ff == mlfqs_pkg::ST_DECAY_MUL || state_ff == mlfqs_pkg::ST_LOAD_MUL ||
          state_ff == mlfqs_pkg::ST_RPT_MULRC || state_ff == mlfqs_pkg::ST_RPT_MULLA) begin
         mul_ff <= mul_a * mul_b;
      end
      if (state_ff == mlfqs_pkg::ST_RPT_MULLA) rc100_ff <= sat32((PW+1)'(rnd_t));
      if (state_ff == mlfqs_pkg::ST_RPT_OUT && out_go) begin
         rsp_pri_ff   <= rd_pri;
         rsp_rc_ff    <= rc100_ff;
         rsp_la_ff    <= la100;
         rsp_yield_ff <= yield_ff;
      end
   end

   assign req_stall           = (state_ff != mlfqs_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_priority_out    = rsp_pri_ff;
   assign rsp_recent_cpu_x100 = rsp_rc_ff;
   assign rsp_load_avg_x100   = rsp_la_ff;
   assign rsp_yield_now       = rsp_yield_ff;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlfqs_pkg::ST_RPT_OUT && out_go) |=> rsp_valid_ff)
      else $error("finished item produced no result beat");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlfqs_pkg::ST_IDLE) |-> !mem_we)
      else $error("table written while idle");

   a_written_mark: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> wr_ff[$past(mem_waddr)])
      else $error("written slot not marked");

   a_load_nonneg: assert property (@(posedge clock) disable iff (reset)
      !la_ff[31])
      else $error("load average went negative");

   a_tick_only_yield: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode != mlfqs_pkg::OP_TICK) |=> !yield_ff)
      else $error("yield flagged on a non-tick beat");
`endif

endmodule
`default_nettype wire

// ===== bench/mlfqs_checker.sv =====
// Scoreboard for the MLFQS priority engine: shadow statistics table and beat compare.
`timescale 1ns / 1ps
`default_nettype none
module mlfqs_checker
   import mlfqs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [5:0]         req_slot,
   input  wire logic [5:0]         req_parent_slot,
   input  wire logic signed [5:0]  req_nice_value,
   input  wire logic [6:0]         req_ready_count,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [5:0]         rsp_priority_out,
   input  wire logic signed [31:0] rsp_recent_cpu_x100,
   input  wire logic [12:0]        rsp_load_avg_x100,
   input  wire logic               rsp_yield_now,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [9:0]         csr_data,
   output int                      fail_count,
   output int                      pending_count
);

   localparam longint ONE = 64'sd1 << 14;

   typedef struct packed {
      logic [5:0]         pri;
      logic signed [31:0] rc100;
      logic [12:0]        la100;
      logic               yld;
   } stat_beat_t;

   stat_beat_t stat_queue[$];

   logic signed [5:0]  nice_tab [64];
   logic signed [31:0] cpu_tab [64];
   logic [5:0]         pri_tab [64];
   logic               live_tab [64];
   logic signed [31:0] load_avg;
   int unsigned        slices;
   logic [31:0]        ticks;
   logic               mlfqs_en;
   logic [5:0]         idle_id;
   logic [9:0]         tps_reg;
   logic [7:0]         slice_reg;

   assign pending_count = stat_queue.size();

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint scale100(logic signed [31:0] fp);
      longint v;
      v = longint'(fp) * 100;
      if (v >= 0) return (v + ONE / 2) / ONE;
      return (v - ONE / 2) / ONE;
   endfunction

   function automatic void refresh_pri(int s);
      longint v;
      if (s == idle_id) return;
      v = 63 * ONE - longint'(cpu_tab[s]) / 4 - 2 * longint'(nice_tab[s]) * ONE;
      v = v / ONE;
      if (v > 63) v = 63;
      if (v < 0) v = 0;
      pri_tab[s] = v[5:0];
   endfunction

   function automatic void decay_cpu(int s);
      longint twice, den, coeff;
      if (s == idle_id) return;
      twice = longint'(load_avg) * 2;
      den = twice + ONE;
      coeff = (den != 0) ? (twice * ONE) / den : 0;
      cpu_tab[s] = clip32((coeff * longint'(cpu_tab[s])) / ONE
                          + longint'(nice_tab[s]) * ONE);
   endfunction

   // advance the shadow state by one request and queue its result
   function automatic void apply_request(logic [2:0] op, int s, int p,
                                         logic signed [5:0] nv_in, int ready);
      int nv, tps;
      longint n, rc, la;
      logic yld;
      logic signed [5:0]  pn;
      logic signed [31:0] pc;
      stat_beat_t b;
      nv = nv_in;
      if (nv > NICE_MAX) nv = NICE_MAX;
      if (nv < -NICE_MAX) nv = -NICE_MAX;
      yld = 1'b0;
      case (op)
         OP_TICK: begin
            ticks = ticks + 1;
            if (mlfqs_en) begin
               if (s != idle_id) cpu_tab[s] = clip32(longint'(cpu_tab[s]) + ONE);
               tps = (tps_reg == 0) ? 1 : tps_reg;
               if (ticks % tps == 0) begin
                  n = ready + ((s != idle_id) ? 1 : 0);
                  load_avg = clip32((((59 * ONE) / 60) * longint'(load_avg)) / ONE
                                    + (ONE / 60) * n);
                  for (int i = 0; i < 64; i++) if (live_tab[i]) decay_cpu(i);
               end
               if (ticks % 4 == 0)
                  for (int i = 0; i < 64; i++) if (live_tab[i]) refresh_pri(i);
            end
            if (slices < 255) slices++;
            if (slices >= slice_reg) yld = 1'b1;
         end
         OP_NEWSLICE: slices = 0;
         OP_CREATE: begin
            pn = nice_tab[p];
            pc = cpu_tab[p];
            nice_tab[s] = 0;
            cpu_tab[s] = 0;
            pri_tab[s] = DEFAULT_PRI;
            live_tab[s] = 1'b1;
            if (mlfqs_en) begin
               nice_tab[s] = pn;
               cpu_tab[s] = pc;
               refresh_pri(s);
            end
         end
         OP_SETNICE: begin
            nice_tab[s] = nv;
            refresh_pri(s);
         end
         OP_EXIT: live_tab[s] = 1'b0;
         default: ;
      endcase
      rc = scale100(cpu_tab[s]);
      la = scale100(load_avg);
      if (la < 0) la = 0;
      if (la > LA100_MAX) la = LA100_MAX;
      b.pri = pri_tab[s];
      b.rc100 = clip32(rc);
      b.la100 = la[12:0];
      b.yld = yld;
      stat_queue.push_back(b);
   endfunction

   always @(posedge clock) begin
      stat_beat_t e;
      if (reset) begin
         for (int i = 0; i < 64; i++) begin
            nice_tab[i] = 0;
            cpu_tab[i] = 0;
            pri_tab[i] = DEFAULT_PRI;
            live_tab[i] = 1'b0;
         end
         load_avg = 0;
         slices = 0;
         ticks = 0;
         mlfqs_en = 1'b1;
         idle_id = 0;
         tps_reg = 100;
         slice_reg = 4;
         fail_count = 0;
         stat_queue.delete();
      end else begin
         // config write
         if (csr_write) begin
            case (csr_index)
               CSR_MLFQS_ON:  mlfqs_en = csr_data[0];
               CSR_IDLE_SLOT: idle_id = csr_data[5:0];
               CSR_TPS:       tps_reg = csr_data;
               CSR_SLICE:     slice_reg = csr_data[7:0];
               default: ;
            endcase
         end
         // result beat compare
         if (rsp_valid && !rsp_stall) begin
            if (stat_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
               e = stat_queue.pop_front();
               if (e.pri !== rsp_priority_out || e.rc100 !== rsp_recent_cpu_x100 ||
                   e.la100 !== rsp_load_avg_x100 || e.yld !== rsp_yield_now) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp pri %0d rc %0d la %0d y %0d, got %0d %0d %0d %0d",
                              e.pri, e.rc100, e.la100, e.yld, rsp_priority_out,
                              rsp_recent_cpu_x100, rsp_load_avg_x100, rsp_yield_now);
               end
            end
         end
         // request beat
         if (req_valid && !req_stall)
            apply_request(req_opcode, req_slot, req_parent_slot, req_nice_value,
                          req_ready_count);
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the MLFQS priority engine.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import mlfqs_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_opcode = OP_TICK;
   logic [5:0]        req_slot = '0;
   logic [5:0]        req_parent_slot = '0;
   logic signed [5:0] req_nice_value = '0;
   logic [6:0]        req_ready_count = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [5:0]        rsp_priority_out;
   logic signed [31:0] rsp_recent_cpu_x100;
   logic [12:0]       rsp_load_avg_x100;
   logic              rsp_yield_now;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [9:0]        csr_data = '0;
   int                fail_count;
   int                pending_count;
   logic              hold_off = 1'b0;

   always #5 clock = ~clock;

   mlfqs_priority_engine_unit dut (.*);
   mlfqs_checker checker_i (.*);

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
            rsp_stall <= mode && ($urandom_range(0, 1) == 1);
         end
      end
   end

   // one request beat, waits for accept
   task automatic send_req(logic [2:0] op, logic [5:0] s, logic [5:0] p,
                           logic signed [5:0] nv, logic [6:0] rdy);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot <= s;
      req_parent_slot <= p;
      req_nice_value <= nv;
      req_ready_count <= rdy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   // drain and settle before a config write
   task automatic drain();
      go_idle();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_set(logic [1:0] idx, logic [9:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // random request mix: mostly ticks over a few live threads
   task automatic random_req();
      int k;
      logic [2:0] op;
      k = $urandom_range(0, 99);
      if (k < 55) op = OP_TICK;
      else if (k < 65) op = OP_NEWSLICE;
      else if (k < 78) op = OP_CREATE;
      else if (k < 90) op = OP_SETNICE;
      else if (k < 97) op = OP_EXIT;
      else op = $urandom_range(5, 7);
      send_req(op, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom(), $urandom_range(0, 127));
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && count > 0) begin
            random_req();
            burst--;
            count--;
         end
         if ($urandom_range(0, 1)) begin
            go_idle();
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, all opcodes, special cases
      send_req(OP_CREATE, 1, 0, 0, 0);
      send_req(OP_CREATE, 63, 1, 0, 0);
      send_req(OP_SETNICE, 1, 0, 6'sd20, 0);
      send_req(OP_SETNICE, 63, 0, -6'sd20, 0);
      send_req(OP_SETNICE, 2, 0, 6'sd31, 0);
      send_req(OP_SETNICE, 3, 0, -6'sd32, 0);
      send_req(OP_SETNICE, 0, 0, 6'sd5, 0);
      send_req(OP_TICK, 1, 0, 0, 7'd127);
      send_req(OP_TICK, 5, 0, 0, 7'd64);
      send_req(OP_TICK, 0, 0, 0, 0);
      send_req(OP_TICK, 63, 63, 0, 7'd64);
      send_req(OP_CREATE, 5, 63, 0, 0);
      send_req(OP_NEWSLICE, 1, 0, 0, 0);
      send_req(OP_EXIT, 63, 0, 0, 0);
      send_req(3'd5, 1, 0, 0, 0);
      send_req(3'd7, 63, 0, 0, 0);
      send_req(OP_TICK, 6, 0, 0, 0);
      drain();
      // fast seconds, zero slice and zero rate
      csr_set(CSR_TPS, 0);
      csr_set(CSR_SLICE, 0);
      random_phase(200);
      drain();
      csr_set(CSR_TPS, 1);
      csr_set(CSR_SLICE, 255);
      csr_set(CSR_IDLE_SLOT, 63);
      random_phase(200);
      // sender pause until all results are back
      drain();
      csr_set(CSR_MLFQS_ON, 0);
      csr_set(CSR_TPS, 1000);
      csr_set(CSR_SLICE, 1);
      random_phase(150);
      drain();
      csr_set(CSR_MLFQS_ON, 1);
      csr_set(CSR_IDLE_SLOT, 3);
      csr_set(CSR_TPS, 3);
      csr_set(CSR_SLICE, 7);
      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      random_phase(40);
      random_phase(300);
      drain();
      csr_set(CSR_TPS, 7);
      csr_set(CSR_IDLE_SLOT, 0);
      random_phase(300);
      drain();
      if (fail_count == 0) $display("mlfqs_priority_engine_unit verification clean");
      else $display("mlfqs_priority_engine_unit verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("mlfqs_priority_engine_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
